>>> src/b64lw_pkg.sv
// Shared types, constants and the alphabet lookup for the Base64 encoder
// with line wrapping. Depends on nothing; every other file uses it.
`timescale 1ns / 1ps
`default_nettype none

package b64lw_pkg;

   // Default line length in characters (CR LF not counted).
   localparam int LINE_CHARS_DEFAULT = 76;

   // Most characters that one input item can cause: four symbols and CR LF.
   localparam int MAX_CHARS = 6;
   localparam int CNT_W     = $clog2(MAX_CHARS + 1);

   localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   typedef logic [CNT_W-1:0] count_type;

   // Characters of one item, handed from the encoder to the output buffer.
   typedef struct packed {
      logic                           load;      // buffer takes this group
      count_type                      count;     // number of valid characters
      logic                           msg_last;  // item ended the message
      logic [MAX_CHARS-1:0][7:0]      chars;     // character 0 is sent first
   } group_type;

   // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [7:0] v8;
      logic [7:0] c;
      v8 = {2'b00, v};
      if (v < 6'd26) begin
         c = v8 + 8'd65;
      end else if (v < 6'd52) begin
         c = v8 + 8'd71;
      end else if (v < 6'd62) begin
         c = v8 - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> src/b64lw_encode.sv
// Encoder stage: group state, line count and the characters of one item.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_encode #(
   parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [7:0]            in_data,
   input  wire logic                  in_last,
   input  wire logic                  buf_free,
   output logic                       advance,
   output b64lw_pkg::group_type       group
);

   localparam int GROUPS = LINE_CHARS / 4;
   localparam int LGW    = $clog2(GROUPS + 1);
   localparam logic [LGW-1:0] GROUPS_C = LGW'(GROUPS);

   logic [1:0]      phase_ff,   phase_in;
   logic [15:0]     pending_ff, pending_in;
   logic [LGW-1:0]  lines_ff,   lines_in;

   logic [1:0]      phase;
   logic [7:0]      b0, b1;
   logic [23:0]     w;
   logic [LGW-1:0]  lines_inc;
   logic            wrap;

   always_comb begin
      phase     = (phase_ff == 2'd3) ? 2'd0 : phase_ff;
      b0        = pending_ff[15:8];
      b1        = pending_ff[7:0];
      w         = {b0, b1, in_data};
      lines_inc = lines_ff + LGW'(1);
      wrap      = (lines_inc >= GROUPS_C);

      phase_in       = phase_ff;
      pending_in     = pending_ff;
      lines_in       = lines_ff;
      group.chars    = '0;
      group.count    = '0;
      group.msg_last = in_last;

      if (phase == 2'd2) begin
         group.chars[0] = b64lw_pkg::sym(w[23:18]);
         group.chars[1] = b64lw_pkg::sym(w[17:12]);
         group.chars[2] = b64lw_pkg::sym(w[11:6]);
         group.chars[3] = b64lw_pkg::sym(w[5:0]);
         if (wrap) begin
            group.chars[4] = b64lw_pkg::CHAR_CR;
            group.chars[5] = b64lw_pkg::CHAR_LF;
            group.count    = b64lw_pkg::count_type'(6);
            lines_in       = '0;
         end else begin
            group.count = b64lw_pkg::count_type'(4);
            lines_in    = lines_inc;
         end
         phase_in   = 2'd0;
         pending_in = '0;
      end else if (in_last) begin
         group.count = b64lw_pkg::count_type'(4);
         if (phase == 2'd0) begin
            group.chars[0] = b64lw_pkg::sym(in_data[7:2]);
            group.chars[1] = b64lw_pkg::sym({in_data[1:0], 4'b0000});
            group.chars[2] = b64lw_pkg::CHAR_PAD;
            group.chars[3] = b64lw_pkg::CHAR_PAD;
         end else begin
            group.chars[0] = b64lw_pkg::sym(b0[7:2]);
            group.chars[1] = b64lw_pkg::sym({b0[1:0], in_data[7:4]});
            group.chars[2] = b64lw_pkg::sym({in_data[3:0], 2'b00});
            group.chars[3] = b64lw_pkg::CHAR_PAD;
         end
      end else if (phase == 2'd0) begin
         pending_in = {in_data, 8'h00};
         phase_in   = 2'd1;
      end else begin
         pending_in = {b0, in_data};
         phase_in   = 2'd2;
      end

      // The end of a message returns everything to the reset state.
      if (in_last) begin
         phase_in   = '0;
         pending_in = '0;
         lines_in   = '0;
      end

      // An item that only gathers a byte never waits for the buffer.
      advance    = in_valid && ((group.count == '0) || buf_free);
      group.load = advance && (group.count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         pending_ff <= '0;
         lines_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         lines_ff   <= lines_in;
      end
   end

endmodule

`default_nettype wire

>>> src/b64lw_serial.sv
// Output buffer: holds the characters of one item and sends one per cycle unless stalled.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_serial (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire b64lw_pkg::group_type  group,
   output logic                       buf_free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_run_last,
   output logic                       rsp_message_end
);

   logic [b64lw_pkg::MAX_CHARS-1:0][7:0] chars_ff;
   b64lw_pkg::count_type                 count_ff;
   b64lw_pkg::count_type                 idx_ff;
   logic                                 msg_last_ff;
   logic                                 take;
   logic                                 final_char;

   always_comb begin
      rsp_valid       = (count_ff != '0);
      final_char      = (idx_ff == (count_ff - b64lw_pkg::count_type'(1)));
      take            = rsp_valid && !rsp_stall;
      buf_free        = !rsp_valid || (take && final_char);
      rsp_out_char    = chars_ff[idx_ff];
      rsp_run_last    = final_char;
      rsp_message_end = final_char && msg_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (group.load) begin
         count_ff <= group.count;
         idx_ff   <= '0;
      end else if (take) begin
         if (final_char) begin
            count_ff <= '0;
            idx_ff   <= '0;
         end else begin
            idx_ff <= idx_ff + b64lw_pkg::count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (group.load) begin
         chars_ff    <= group.chars;
         msg_last_ff <= group.msg_last;
      end
   end

endmodule

`default_nettype wire

>>> src/base64_encoder_line_wrap.sv
// An accepted byte waits in the input register, is encoded combinationally, and its
// characters are registered in the output buffer before the first one is offered.
// Throughput: one byte per cycle while bytes are only gathered; a completed group
//   occupies the character output for its four characters, or six with CR LF after it.
// The single character output sets the rate on a stream.
// Reset is synchronous and active high; it empties both stages and clears the state.
`timescale 1ns / 1ps
`default_nettype none

module base64_encoder_line_wrap #(
   parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_message_end
);

   // The input register holds one accepted item. It is released as soon as
   // the encoder can pass it on: at once for a byte that only joins the
   // pending group, or when the output buffer is empty or sends its final
   // character in this cycle for a byte that produces characters. A new item
   // is taken in the same cycle as the register is released, so bytes can
   // follow one another without a gap.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;

   logic                 advance;
   logic                 buf_free;
   b64lw_pkg::group_type group;

   always_comb begin
      req_stall   = in_valid_ff && !advance;
      in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // The encoder keeps the pending bytes, the position in the three-byte
   // group and the number of complete groups on the current line, and forms
   // every character that the held item causes in a single pass.
   b64lw_encode #(
      .LINE_CHARS (LINE_CHARS)
   ) u_encode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_data  (in_data_ff),
      .in_last  (in_last_ff),
      .buf_free (buf_free),
      .advance  (advance),
      .group    (group)
   );

   // The output buffer stores up to six characters and presents them one
   // per cycle while rsp_stall is low, marking the final character of each
   // item and, for the item that ends the message, the end of the whole message.
   b64lw_serial u_serial (
      .clock           (clock),
      .reset           (reset),
      .group           (group),
      .buf_free        (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end)
   );

endmodule

`default_nettype wire
